@@ hw/rtl/gbp_pkg.sv @@
// Package for the glyph bitplane packer: frame geometry, command codes and
// the frame RAM request struct. No dependencies.
`default_nettype none

package gbp_pkg;

   localparam int ROWS          = 7;
   localparam int BYTES_PER_ROW = 35;
   localparam int FRAME_SIZE    = ROWS * BYTES_PER_ROW;
   localparam int ADDR_W        = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
   localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam int CURSOR_W      = 9;
   localparam int LIMIT_W       = 9;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd270;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PLACE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } gbp_ram_req_type;

endpackage

`default_nettype wire

@@ hw/rtl/gbp_if.sv @@
// Valid/ready channel interfaces for the packer's command and result streams.
// Depends on nothing; widths are fixed by the field definitions.
`default_nettype none

interface gbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [55:0] glyph_rows;
   logic [3:0]  glyph_width;
   logic [2:0]  read_row;
   logic [5:0]  read_byte;

   modport source (output valid, command, glyph_rows, glyph_width, read_row, read_byte,
                   input ready);
   modport sink   (input valid, command, glyph_rows, glyph_width, read_row, read_byte,
                   output ready);
endinterface

interface gbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [8:0] cursor_position;
   logic       glyph_dropped;

   modport source (output valid, read_data, cursor_position, glyph_dropped, input ready);
   modport sink   (input valid, read_data, cursor_position, glyph_dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gbp_frame_ram.sv @@
// Frame store: one byte-wide synchronous RAM with a registered read and
// per-byte valid bits so a clear resets every byte together. Depends on gbp_pkg.
`default_nettype none

module gbp_frame_ram (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire gbp_pkg::gbp_ram_req_type ram_req,
   output logic [7:0]                    rd_data
);

   logic [7:0]                      mem [gbp_pkg::FRAME_SIZE];
   logic [gbp_pkg::FRAME_SIZE-1:0]  valid_ff;
   logic [7:0]                      rd_data_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ram_req.clear) begin
            valid_ff <= '0;
         end else if (ram_req.wr_en) begin
            valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_valid_ff <= valid_ff[ram_req.rd_addr];
         end
      end
   end

   // never-written bytes read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

`default_nettype wire

@@ hw/rtl/gbp_seq.sv @@
// Command sequencer: decodes commands, runs the read-modify-write sweep over
// the frame RAM for a glyph, keeps the cursor and the result register.
// Depends on gbp_pkg and gbp_if.
`default_nettype none

module gbp_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   gbp_req_if.sink                            req_chan,
   gbp_rsp_if.source                          rsp_chan,
   input  wire logic [gbp_pkg::LIMIT_W-1:0]   screen_limit,
   output gbp_pkg::gbp_ram_req_type           ram_req,
   input  wire logic [7:0]                    ram_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_PLACE,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [gbp_pkg::CURSOR_W-1:0]     cursor_ff, cursor_in;
   logic [55:0]                      rows_ff, rows_in;
   logic [3:0]                       width_ff, width_in;
   logic [5:0]                       idx_ff, idx_in;
   logic [2:0]                       off_ff, off_in;
   logic [gbp_pkg::ROW_W-1:0]        row_ff, row_in;
   logic                             half_ff, half_in;
   logic [gbp_pkg::ADDR_W-1:0]       base_ff, base_in;
   logic                             in_range_ff, in_range_in;
   logic [7:0]                       res_data_ff, res_data_in;
   logic                             res_drop_ff, res_drop_in;

   logic                             pend_en_ff, pend_en_in;
   logic [gbp_pkg::ADDR_W-1:0]       pend_addr_ff, pend_addr_in;
   logic [7:0]                       pend_bits_ff, pend_bits_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_data_ff, rsp_data_in;
   logic [gbp_pkg::CURSOR_W-1:0]     rsp_cursor_ff, rsp_cursor_in;
   logic                             rsp_drop_ff, rsp_drop_in;

   logic                             accept;
   logic                             rsp_free;
   logic [7:0]                       row_byte;
   logic [15:0]                      wide;
   logic [6:0]                       tgt_idx;
   logic                             tgt_ok;
   logic [gbp_pkg::CURSOR_W:0]       cursor_sum;
   logic                             rd_ok;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign row_byte   = 8'(rows_ff >> {row_ff, 3'b000});
   assign wide       = {8'h00, row_byte} << off_ff;
   assign tgt_idx    = 7'(idx_ff) + 7'(half_ff);
   assign tgt_ok     = (int'(tgt_idx) < gbp_pkg::BYTES_PER_ROW);
   assign cursor_sum = {1'b0, cursor_ff} + (gbp_pkg::CURSOR_W + 1)'(width_ff);
   assign rd_ok      = (int'(req_chan.read_row) < gbp_pkg::ROWS) &&
                       (int'(req_chan.read_byte) < gbp_pkg::BYTES_PER_ROW);

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      rows_in       = rows_ff;
      width_in      = width_ff;
      idx_in        = idx_ff;
      off_in        = off_ff;
      row_in        = row_ff;
      half_in       = half_ff;
      base_in       = base_ff;
      in_range_in   = in_range_ff;
      res_data_in   = res_data_ff;
      res_drop_in   = res_drop_ff;
      pend_en_in    = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_bits_in  = pend_bits_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_drop_in   = rsp_drop_ff;

      ram_req.clear   = 1'b0;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = '0;
      ram_req.wr_en   = pend_en_ff;
      ram_req.wr_addr = pend_addr_ff;
      ram_req.wr_data = ram_rd_data | pend_bits_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rows_in     = req_chan.glyph_rows;
               width_in    = req_chan.glyph_width;
               res_data_in = 8'h00;
               res_drop_in = 1'b0;
               state_in    = ST_FINISH;
               unique case (req_chan.command)
                  gbp_pkg::CMD_CLEAR: begin
                     ram_req.clear = 1'b1;
                     cursor_in     = '0;
                  end
                  gbp_pkg::CMD_PLACE: begin
                     if (cursor_ff > screen_limit) begin
                        res_drop_in = 1'b1;
                     end else begin
                        idx_in   = cursor_ff[8:3];
                        off_in   = cursor_ff[2:0];
                        row_in   = '0;
                        half_in  = 1'b0;
                        base_in  = '0;
                        state_in = ST_PLACE;
                     end
                  end
                  gbp_pkg::CMD_READ: begin
                     in_range_in     = rd_ok;
                     ram_req.rd_en   = rd_ok;
                     ram_req.rd_addr = gbp_pkg::ADDR_W'(
                        int'(req_chan.read_row) * gbp_pkg::BYTES_PER_ROW +
                        int'(req_chan.read_byte));
                     state_in        = ST_RD_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_data_in = in_range_ff ? ram_rd_data : 8'h00;
            state_in    = ST_FINISH;
         end
         ST_PLACE: begin
            ram_req.rd_en   = tgt_ok;
            ram_req.rd_addr = gbp_pkg::ADDR_W'(int'(base_ff) + int'(tgt_idx));
            pend_en_in      = tgt_ok;
            pend_addr_in    = ram_req.rd_addr;
            pend_bits_in    = half_ff ? wide[15:8] : wide[7:0];
            half_in         = !half_ff;
            if (half_ff) begin
               row_in  = row_ff + 1'b1;
               base_in = gbp_pkg::ADDR_W'(int'(base_ff) + gbp_pkg::BYTES_PER_ROW);
               if (row_ff == gbp_pkg::ROW_W'(gbp_pkg::ROWS - 1)) begin
                  cursor_in = cursor_sum[gbp_pkg::CURSOR_W] ? '1 :
                              cursor_sum[gbp_pkg::CURSOR_W-1:0];
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_cursor_in = cursor_ff;
               rsp_drop_in   = res_drop_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         pend_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         pend_en_ff   <= pend_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rows_ff       <= rows_in;
      width_ff      <= width_in;
      idx_ff        <= idx_in;
      off_ff        <= off_in;
      row_ff        <= row_in;
      half_ff       <= half_in;
      base_ff       <= base_in;
      in_range_ff   <= in_range_in;
      res_data_ff   <= res_data_in;
      res_drop_ff   <= res_drop_in;
      pend_addr_ff  <= pend_addr_in;
      pend_bits_ff  <= pend_bits_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.read_data       = rsp_data_ff;
   assign rsp_chan.cursor_position = rsp_cursor_ff;
   assign rsp_chan.glyph_dropped   = rsp_drop_ff;

   a_no_rw_same_addr: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
      else $error("frame RAM read and write hit the same byte");

   a_wr_in_frame: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> int'(ram_req.wr_addr) < gbp_pkg::FRAME_SIZE)
      else $error("frame RAM write outside the frame");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_req.wr_en)
      else $error("glyph write still pending when a new command can start");

   a_drop_keeps_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_free && res_drop_ff |-> rsp_cursor_in == cursor_ff &&
      !rsp_drop_ff || rsp_drop_in)
      else $error("dropped glyph result lost its flag");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("command transfer did not start a sequence");

endmodule

`default_nettype wire

@@ hw/rtl/glyph_bitplane_packer_core.sv @@
// Glyph bitplane packer top level: screen limit register, command sequencer
// and frame RAM. Depends on gbp_pkg, gbp_if, gbp_seq and gbp_frame_ram.
// Place: a read-modify-write sweep over two bytes per row, at most one RAM
// read and one write per cycle. Read: a registered RAM read, then the result.
// Clear, dropped glyph and unused command go straight to the result. One command
// in flight; the next is taken as soon as the result sits in the output register.
// Reset (synchronous): frame reads as zero, cursor 0, screen limit 270.
`default_nettype none

module glyph_bitplane_packer_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   gbp_req_if.sink                           req_chan,
   gbp_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [gbp_pkg::LIMIT_W-1:0]  csr_wr_data
);

   logic [gbp_pkg::LIMIT_W-1:0] screen_limit_ff, screen_limit_in;
   gbp_pkg::gbp_ram_req_type    ram_req;
   logic [7:0]                  ram_rd_data;

   assign screen_limit_in = csr_wr_en ? csr_wr_data : screen_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_limit_ff <= gbp_pkg::LIMIT_RESET;
      end else begin
         screen_limit_ff <= screen_limit_in;
      end
   end

   gbp_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .screen_limit (screen_limit_ff),
      .ram_req      (ram_req),
      .ram_rd_data  (ram_rd_data)
   );

   gbp_frame_ram u_frame_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
